// ===== hdl/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg : ray box slab test shared definitions
// Widths, register indexes and the per-lane result struct.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int DIR_WIDTH   = 16;
   localparam int NUM_AXES    = 3;
   localparam int SCALE_SHIFT = DIR_WIDTH - 2;
   // dividend: difference (COORD_WIDTH+1) scaled by the direction fraction bits
   localparam int NUM_WIDTH   = COORD_WIDTH + 1 + SCALE_SHIFT;
   // magnitude widths of the restoring divider
   localparam int QMAG_WIDTH  = NUM_WIDTH;
   localparam int DMAG_WIDTH  = DIR_WIDTH;
   localparam int DIV_STEPS   = QMAG_WIDTH;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int REQ_DATA_WIDTH = ((3 * COORD_WIDTH + 3 * DIR_WIDTH + 7) / 8) * 8;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_X = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAX_X = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAX_Z = 3'd5;

   // per-lane result handed to the merge stage
   typedef struct packed {
      logic                          bounded;  // axis sets entry/exit
      logic                          miss;     // zero direction, origin outside slab
      logic signed [COORD_WIDTH-1:0] t_near;
      logic signed [COORD_WIDTH-1:0] t_far;
   } lane_res_type;

endpackage

// ===== hdl/rbst_lane.sv =====
// ----------------------------------------------------------------------------
// rbst_lane : one axis slab lane
// Pipelined signed division of both slab bounds, saturation and ordering.
// Accepts one ray per cycle when enabled.
// ----------------------------------------------------------------------------
module rbst_lane (
   input  logic                                   clock,
   input  logic                                   enable,
   input  logic signed [rbst_pkg::COORD_WIDTH-1:0] origin,
   input  logic signed [rbst_pkg::DIR_WIDTH-1:0]   dir,
   input  logic signed [rbst_pkg::COORD_WIDTH-1:0] bound_lo,
   input  logic signed [rbst_pkg::COORD_WIDTH-1:0] bound_hi,
   output rbst_pkg::lane_res_type                  result
);
   import rbst_pkg::*;

   localparam int NS = DIV_STEPS;

   // divider pipeline registers, two quotients sharing one divisor
   logic [QMAG_WIDTH-1:0] rem1_ff [NS+1];
   logic [QMAG_WIDTH-1:0] rem2_ff [NS+1];
   logic [QMAG_WIDTH-1:0] num1_ff [NS+1];
   logic [QMAG_WIDTH-1:0] num2_ff [NS+1];
   logic [DMAG_WIDTH-1:0] den_ff  [NS+1];
   logic                  neg1_ff [NS+1];
   logic                  neg2_ff [NS+1];
   logic                  zero_ff [NS+1];
   logic                  inside_ff [NS+1];
   lane_res_type          result_ff;

   logic signed [COORD_WIDTH:0] diff1, diff2;
   logic signed [NUM_WIDTH-1:0] sc1, sc2;
   logic [QMAG_WIDTH-1:0]       mag1, mag2;
   logic [DMAG_WIDTH-1:0]       dmag;
   logic                        in_slab;

   // stage 0: differences, scaling and magnitudes
   always_comb begin
      diff1 = {bound_lo[COORD_WIDTH-1], bound_lo} - {origin[COORD_WIDTH-1], origin};
      diff2 = {bound_hi[COORD_WIDTH-1], bound_hi} - {origin[COORD_WIDTH-1], origin};
      sc1   = {diff1, {SCALE_SHIFT{1'b0}}};
      sc2   = {diff2, {SCALE_SHIFT{1'b0}}};
      mag1  = sc1[NUM_WIDTH-1] ? QMAG_WIDTH'(-sc1) : QMAG_WIDTH'(sc1);
      mag2  = sc2[NUM_WIDTH-1] ? QMAG_WIDTH'(-sc2) : QMAG_WIDTH'(sc2);
      dmag  = dir[DIR_WIDTH-1] ? DMAG_WIDTH'(-dir) : DMAG_WIDTH'(dir);
      in_slab = (bound_lo <= origin && origin <= bound_hi) ||
                (bound_hi <= origin && origin <= bound_lo);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem1_ff[0]   <= '0;
         rem2_ff[0]   <= '0;
         num1_ff[0]   <= mag1;
         num2_ff[0]   <= mag2;
         den_ff[0]    <= dmag;
         neg1_ff[0]   <= sc1[NUM_WIDTH-1] ^ dir[DIR_WIDTH-1];
         neg2_ff[0]   <= sc2[NUM_WIDTH-1] ^ dir[DIR_WIDTH-1];
         zero_ff[0]   <= (dir == '0);
         inside_ff[0] <= in_slab;
      end
   end

   // restoring division, one quotient bit per stage; num shifts into quotient
   for (genvar s = 0; s < NS; s++) begin : g_div
      logic [QMAG_WIDTH:0]   t1, t2;
      logic [QMAG_WIDTH-1:0] r1_in, r2_in, n1_in, n2_in;
      always_comb begin
         t1 = {rem1_ff[s], num1_ff[s][QMAG_WIDTH-1]} - {{(QMAG_WIDTH-DMAG_WIDTH+1){1'b0}}, den_ff[s]};
         t2 = {rem2_ff[s], num2_ff[s][QMAG_WIDTH-1]} - {{(QMAG_WIDTH-DMAG_WIDTH+1){1'b0}}, den_ff[s]};
         r1_in = t1[QMAG_WIDTH] ? {rem1_ff[s][QMAG_WIDTH-2:0], num1_ff[s][QMAG_WIDTH-1]}
                                : t1[QMAG_WIDTH-1:0];
         r2_in = t2[QMAG_WIDTH] ? {rem2_ff[s][QMAG_WIDTH-2:0], num2_ff[s][QMAG_WIDTH-1]}
                                : t2[QMAG_WIDTH-1:0];
         n1_in = {num1_ff[s][QMAG_WIDTH-2:0], ~t1[QMAG_WIDTH]};
         n2_in = {num2_ff[s][QMAG_WIDTH-2:0], ~t2[QMAG_WIDTH]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem1_ff[s+1]   <= r1_in;
            rem2_ff[s+1]   <= r2_in;
            num1_ff[s+1]   <= n1_in;
            num2_ff[s+1]   <= n2_in;
            den_ff[s+1]    <= den_ff[s];
            neg1_ff[s+1]   <= neg1_ff[s];
            neg2_ff[s+1]   <= neg2_ff[s];
            zero_ff[s+1]   <= zero_ff[s];
            inside_ff[s+1] <= inside_ff[s];
         end
      end
   end

   // sign, saturation and ordering of the two slab parameters
   localparam logic [QMAG_WIDTH-1:0] POS_LIM = QMAG_WIDTH'((64'd1 << (COORD_WIDTH-1)) - 64'd1);
   localparam logic [QMAG_WIDTH-1:0] NEG_LIM = QMAG_WIDTH'(64'd1 << (COORD_WIDTH-1));

   function automatic logic signed [COORD_WIDTH-1:0] sat_q(
      input logic [QMAG_WIDTH-1:0] q, input logic neg);
      logic signed [COORD_WIDTH-1:0] r;
      if (neg) begin
         if (q >= NEG_LIM) r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         else              r = -$signed(q[COORD_WIDTH-1:0]);
      end else begin
         if (q >= POS_LIM) r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         else              r = $signed(q[COORD_WIDTH-1:0]);
      end
      return r;
   endfunction

   logic signed [COORD_WIDTH-1:0] ta, tb;
   lane_res_type                  result_in;

   always_comb begin
      ta = sat_q(num1_ff[NS], neg1_ff[NS]);
      tb = sat_q(num2_ff[NS], neg2_ff[NS]);
      result_in.bounded = ~zero_ff[NS];
      result_in.miss    = zero_ff[NS] & ~inside_ff[NS];
      result_in.t_near  = (ta < tb) ? ta : tb;
      result_in.t_far   = (ta < tb) ? tb : ta;
   end

   always_ff @(posedge clock) begin
      if (enable) result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== hdl/rbst_merge.sv =====
// ----------------------------------------------------------------------------
// rbst_merge : combine lane results into a hit decision
// Largest entry against smallest exit over the bounded axes.
// ----------------------------------------------------------------------------
module rbst_merge (
   input  rbst_pkg::lane_res_type lanes [rbst_pkg::NUM_AXES],
   output logic                   hit
);
   import rbst_pkg::*;

   always_comb begin
      logic signed [COORD_WIDTH-1:0] enter, leave;
      logic any, miss;
      enter = '0;
      leave = '0;
      any   = 1'b0;
      miss  = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         miss = miss | lanes[a].miss;
         if (lanes[a].bounded) begin
            if (!any || lanes[a].t_near > enter) enter = lanes[a].t_near;
            if (!any || lanes[a].t_far < leave)  leave = lanes[a].t_far;
            any = 1'b1;
         end
      end
      if (any && (leave < 0 || enter > leave)) miss = 1'b1;
      hit = ~miss;
   end

endmodule

// ===== hdl/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test : ray versus axis-aligned box slab test
// Three axis lanes with pipelined dividers feed a merge stage and skid buffer.
// ----------------------------------------------------------------------------
// The pipeline advances, accepting one ray per clock cycle, whenever the
// two-entry output skid queue has a free slot or is being drained, so the
// input stays ready while one result waits. Each hit flag passes the input
// register, bit-per-stage restoring divider and output register of each
// axis lane, then the queue. Box corners must be written through the csr
// channel only while the block is idle; the block itself does not enforce it.
module ray_box_slab_test (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [rbst_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hit_flag, padded to a byte
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [rbst_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [rbst_pkg::COORD_WIDTH-1:0]   csr_data
);
   import rbst_pkg::*;

   localparam int LAT = DIV_STEPS + 2;

   logic signed [COORD_WIDTH-1:0] lo_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] hi_ff [NUM_AXES];

   // box corner registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            lo_ff[a] <= '0;
            hi_ff[a] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MIN_X: lo_ff[0] <= csr_data;
            REG_MIN_Y: lo_ff[1] <= csr_data;
            REG_MIN_Z: lo_ff[2] <= csr_data;
            REG_MAX_X: hi_ff[0] <= csr_data;
            REG_MAX_Y: hi_ff[1] <= csr_data;
            REG_MAX_Z: hi_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // output skid queue of two entries; pipeline moves when a slot is free or on a pop
   logic [1:0] cnt_ff, cnt_in;
   logic       q_ff [2];
   logic       q_in [2];
   logic       advance, accept, pop, done;
   logic [LAT-1:0] vld_ff;
   logic       hit;

   assign advance    = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !(vld_ff[LAT-1])) || pop
                       || (cnt_ff == 2'd1);
   assign req_tready = advance;
   assign accept     = req_tvalid & req_tready;
   assign done       = advance & vld_ff[LAT-1];
   assign pop        = rsp_tvalid & rsp_tready;

   // valid bits travelling with the lanes
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[LAT-2:0], accept};
   end

   lane_res_type lanes [NUM_AXES];
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      rbst_lane u_lane (
         .clock    (clock),
         .enable   (advance),
         .origin   (req_tdata[a*COORD_WIDTH +: COORD_WIDTH]),
         .dir      (req_tdata[3*COORD_WIDTH + a*DIR_WIDTH +: DIR_WIDTH]),
         .bound_lo (lo_ff[a]),
         .bound_hi (hi_ff[a]),
         .result   (lanes[a])
      );
   end

   rbst_merge u_merge (.lanes(lanes), .hit(hit));

   always_comb begin
      cnt_in = cnt_ff + {1'b0, done} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   // queue shift on pop, new result into the first free slot
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) q_in[0] = q_ff[1];
      if (done) begin
         if (pop) q_in[cnt_ff[1]] = hit;
         else     q_in[cnt_ff[0]] = hit;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {7'd0, q_ff[0]};

endmodule

// ===== verif/ray_box_slab_test_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_test : ray versus box slab test bench
// Streams rays through the block under random idling on both sides, predicts
// each hit flag from the box corners held here and checks results in order.
// ----------------------------------------------------------------------------
module ray_box_slab_test_test;
   import rbst_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LATENCY = DIV_STEPS + 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIR_WIDTH-1:0]   dir_type;

   typedef struct {
      coord_type origin [3];
      dir_type   dir [3];
   } ray_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [COORD_WIDTH-1:0] csr_data = '0;

   // box corners as the block should hold them
   coord_type box_lo [3];
   coord_type box_hi [3];
   bit hit_queue [$];
   int errors = 0;
   int idle_cycles = 0;

   ray_box_slab_test u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // short gaps mostly, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // slab parameter saturated to Q16.16
   function automatic longint slab_t(longint bound, longint org, longint d);
      longint q;
      q = ((bound - org) * (longint'(1) << SCALE_SHIFT)) / d;
      if (q > 64'sd2147483647) return 64'sd2147483647;
      if (q < -64'sd2147483648) return -64'sd2147483648;
      return q;
   endfunction

   function automatic bit predict_hit(ray_type ray);
      longint enter, leave, o, d, lo, hi, t1, t2;
      bit miss;
      enter = -64'sd9223372036854775807 - 1;
      leave = 64'sd9223372036854775807;
      miss = 1'b0;
      for (int a = 0; a < 3; a++) begin
         o = ray.origin[a];
         d = ray.dir[a];
         lo = box_lo[a];
         hi = box_hi[a];
         if (d == 0) begin
            if (!((lo <= o && o <= hi) || (hi <= o && o <= lo))) miss = 1'b1;
         end else begin
            t1 = slab_t(lo, o, d);
            t2 = slab_t(hi, o, d);
            if ((t1 < t2 ? t1 : t2) > enter) enter = t1 < t2 ? t1 : t2;
            if ((t1 < t2 ? t2 : t1) < leave) leave = t1 < t2 ? t2 : t1;
         end
      end
      if (leave < 0 || enter > leave) miss = 1'b1;
      return !miss;
   endfunction

   // valid stays high after acceptance until a gap or an idle phase drops it
   task automatic send_ray(ray_type ray);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ray.dir[2], ray.dir[1], ray.dir[0],
                    ray.origin[2], ray.origin[1], ray.origin[0]};
      hit_queue.push_back(predict_hit(ray));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_WIDTH-1:0] idx, coord_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx <= REG_MIN_Z) box_lo[idx] = value;
      else if (idx <= REG_MAX_Z) box_hi[idx - REG_MAX_X] = value;
   endtask

   task automatic set_box(coord_type lx, coord_type ly, coord_type lz,
                          coord_type hx, coord_type hy, coord_type hz);
      wait_drained();
      write_reg(REG_MIN_X, lx);
      write_reg(REG_MIN_Y, ly);
      write_reg(REG_MIN_Z, lz);
      write_reg(REG_MAX_X, hx);
      write_reg(REG_MAX_Y, hy);
      write_reg(REG_MAX_Z, hz);
      csr_valid <= 1'b0;
   endtask

   function automatic ray_type make_ray(coord_type ox, coord_type oy, coord_type oz,
                                        dir_type dx, dir_type dy, dir_type dz);
      ray_type r;
      r.origin[0] = ox; r.origin[1] = oy; r.origin[2] = oz;
      r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
      return r;
   endfunction

   // random coordinate: near the box mostly, full range sometimes
   function automatic coord_type rand_coord(int a, bit wide);
      longint lo, hi;
      if (wide || $urandom_range(0, 9) == 0) return coord_type'($urandom);
      lo = box_lo[a] < box_hi[a] ? box_lo[a] : box_hi[a];
      hi = box_lo[a] < box_hi[a] ? box_hi[a] : box_lo[a];
      return coord_type'(lo - 64'sd262144 + ((hi - lo + 64'sd524288) * $urandom_range(0, 1000))
                         / 1000);
   endfunction

   function automatic dir_type rand_dir();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return dir_type'($urandom);
         default: return dir_type'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   task automatic random_rays(int count, bit wide);
      for (int i = 0; i < count; i++)
         send_ray(make_ray(rand_coord(0, wide), rand_coord(1, wide), rand_coord(2, wide),
                           rand_dir(), rand_dir(), rand_dir()));
   endtask

   // field extremes, zero directions inside and outside, saturation, swapped corners
   task automatic test_directed();
      set_box(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
      send_ray(make_ray(-32'sh50000, 0, 0, 16'sh4000, 0, 0));
      send_ray(make_ray(32'sh50000, 0, 0, 16'sh4000, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, 0, 0));
      send_ray(make_ray(32'sh20000, 0, 0, 0, 0, 0));
      send_ray(make_ray(32'sh10000, -32'sh10000, 32'sh10000, 0, 0, 0));
      send_ray(make_ray(32'h80000000, 32'h7fffffff, 0, 16'sh7fff, 16'sh8000, 16'sh1));
      send_ray(make_ray(32'h80000000, 0, 0, 16'sh1, 0, 0));
      send_ray(make_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        16'sh8000, 16'sh7fff, 16'shffff));
      send_ray(make_ray(-32'sh30000, -32'sh30000, -32'sh30000, 16'sh4000, 16'sh4000, 16'sh4000));
      send_ray(make_ray(-32'sh30000, 32'sh30000, 0, 16'sh4000, 16'shc000, 16'sh2000));
      send_ray(make_ray(32'hffffffff, 32'hffffffff, 32'hffffffff,
                        16'shffff, 16'shffff, 16'shffff));
      set_box(32'h7fffffff, 32'sh30000, 32'h80000000, 32'h80000000, -32'sh30000, 32'h7fffffff);
      send_ray(make_ray(0, 0, 0, 16'sh1, 16'sh1, 16'sh1));
      send_ray(make_ray(0, 0, 0, 16'sh8000, 0, 16'sh7fff));
      send_ray(make_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 16'sh1, 0));
      send_ray(make_ray(32'h7fffffff, 0, 32'h80000000, 16'sh8000, 16'sh8000, 16'sh8000));
      // write to an unused index is dropped
      wait_drained();
      write_reg(3'd6, 32'h12345678);
      write_reg(3'd7, 32'h87654321);
      csr_valid <= 1'b0;
      send_ray(make_ray(0, 0, 0, 16'sh4000, 16'sh4000, 16'sh4000));
   endtask

   task automatic test_random_boxes();
      coord_type c [6];
      for (int phase = 0; phase < 12; phase++) begin
         for (int k = 0; k < 6; k++)
            c[k] = (phase % 4 == 3) ? coord_type'($urandom)
                                    : coord_type'($urandom_range(0, 32'h00a0000) - 32'h0050000);
         set_box(c[0], c[1], c[2], c[3], c[4], c[5]);
         random_rays(156, phase % 4 == 3);
      end
   endtask

   task automatic test_pause();
      random_rays(30, 1'b0);
      req_tvalid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      random_rays(30, 1'b0);
   endtask

   // result checker with random back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time, rsp_tdata[0]);
            errors++;
         end else begin
            if (rsp_tdata[0] !== hit_queue[0]) begin
               $display("%0t: hit_flag mismatch, expected %0d, actual %0d",
                        $time, hit_queue[0], rsp_tdata[0]);
               errors++;
            end
            void'(hit_queue.pop_front());
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= gap_len();
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = '0;
         box_hi[a] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pause();
      test_random_boxes();
      wait_drained();
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
